// ===== design/emap_pkg.sv =====
// shared constants, register codes and beat types of the edge map downsampler
package emap_pkg;

  localparam int MAX_CELLS_PER_ROW = 2048;
  localparam int MAX_STEP          = 16;
  localparam int HEIGHT_LIMIT      = 2048;

  localparam int STEP_W  = 5;
  localparam int DIM_W   = 12;
  localparam int EDGE_W  = 8;
  localparam int COORD_W = 11;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 8;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [STEP_W-1:0] DEF_BLOCK_STEP   = 5'd4;
  localparam logic [DIM_W-1:0]  DEF_IMAGE_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]  DEF_IMAGE_HEIGHT = 12'd480;

  localparam logic [1:0] REG_BLOCK_STEP   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  // one finished block segment, handed from front to back
  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic               any;
    logic               row_first;
    logic               row_last;
    logic               last_row;
    logic               last_col;
  } seg_info_t;

  // per cell column: two finished block rows and the block row in progress
  typedef struct packed {
    logic older;
    logic prior;
    logic acc;
  } row_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               boundary_bit;
    logic               frame_end;
  } res_t;

endpackage

// ===== design/emap_pix_if.sv =====
// pixel input channel
interface emap_pix_if;
  logic                        valid;
  logic                        ready;
  logic [emap_pkg::EDGE_W-1:0] edge_value;
  logic                        frame_start;

  modport source (output valid, edge_value, frame_start, input ready);
  modport sink (input valid, edge_value, frame_start, output ready);
endinterface

// ===== design/emap_res_if.sv =====
// result output channel
interface emap_res_if;
  logic                         valid;
  logic                         ready;
  logic [emap_pkg::COORD_W-1:0] out_row;
  logic [emap_pkg::COORD_W-1:0] out_col;
  logic                         boundary_bit;
  logic                         frame_end;

  modport source (output valid, out_row, out_col, boundary_bit, frame_end, input ready);
  modport sink (input valid, out_row, out_col, boundary_bit, frame_end, output ready);
endinterface

// ===== design/edge_map_block_downsample_boundary_top.sv =====
// edge map block downsampler top: config registers, front, queue and back
// takes one pixel beat per cycle while the segment queue has room; the segment of the pixel that
// completes a block goes through a 4-beat segment queue, the back end and an 8-beat result buffer
// result beats leave at one per cycle while res.ready holds; pixel beats stall while the queue
// is full, and the queue drains only while the result buffer has room for the results in flight
// reset loads block_step 4, image_width 640, image_height 480 and zeroes the position
// counters; the row store needs no clearing pass and a register write restarts the frame
module edge_map_block_downsample_boundary_top #(
  parameter int MAX_CELLS_PER_ROW = emap_pkg::MAX_CELLS_PER_ROW,
  parameter int MAX_STEP          = emap_pkg::MAX_STEP
) (
  input  logic                          clk,
  input  logic                          rst,
  emap_pix_if.sink                      pix,
  emap_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [emap_pkg::APB_AW-1:0]   paddr,
  input  logic [emap_pkg::APB_DW-1:0]   pwdata,
  output logic [emap_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int XW  = $clog2(MAX_CELLS_PER_ROW);
  localparam int SEW = $clog2(MAX_STEP + 1);
  localparam int SCW = emap_pkg::STEP_W + SEW;
  localparam int DW  = emap_pkg::DIM_W;
  localparam int MW  = DW + 2;
  localparam int QW  = $bits(emap_pkg::seg_info_t) + XW;

  logic [emap_pkg::STEP_W-1:0] block_step;
  logic [DW-1:0]               image_width;
  logic [DW-1:0]               image_height;

  logic [1:0]     reg_idx;
  logic           cfg_wr, restart;
  logic [SEW-1:0] s_eff;
  logic [DW-1:0]  w_eff, h_eff;

  logic                in_fire, push, q_full, q_empty, q_pop;
  logic [XW-1:0]       push_x, q_x;
  emap_pkg::seg_info_t push_info, q_info;
  logic [QW-1:0]       q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    restart = 1'b0;
    prdata  = '0;
    unique case (reg_idx)
      emap_pkg::REG_BLOCK_STEP: begin
        restart = cfg_wr;
        prdata  = emap_pkg::APB_DW'(block_step);
      end
      emap_pkg::REG_IMAGE_WIDTH: begin
        restart = cfg_wr;
        prdata  = emap_pkg::APB_DW'(image_width);
      end
      emap_pkg::REG_IMAGE_HEIGHT: begin
        restart = cfg_wr;
        prdata  = emap_pkg::APB_DW'(image_height);
      end
      default: begin
        restart = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_step   <= emap_pkg::DEF_BLOCK_STEP;
      image_width  <= emap_pkg::DEF_IMAGE_WIDTH;
      image_height <= emap_pkg::DEF_IMAGE_HEIGHT;
    end else if (cfg_wr) begin
      if (reg_idx == emap_pkg::REG_BLOCK_STEP) begin
        block_step <= pwdata[emap_pkg::STEP_W-1:0];
      end
      if (reg_idx == emap_pkg::REG_IMAGE_WIDTH) begin
        image_width <= pwdata[DW-1:0];
      end
      if (reg_idx == emap_pkg::REG_IMAGE_HEIGHT) begin
        image_height <= pwdata[DW-1:0];
      end
    end
  end

  // zero acts as one, large values saturate
  always_comb begin
    if (block_step == '0) begin
      s_eff = SEW'(1);
    end else if (SCW'(block_step) > SCW'(MAX_STEP)) begin
      s_eff = SEW'(MAX_STEP);
    end else begin
      s_eff = SEW'(block_step);
    end
    if (image_width == '0) begin
      w_eff = DW'(1);
    end else if (MW'(image_width) > MW'(MAX_CELLS_PER_ROW)) begin
      w_eff = DW'(MAX_CELLS_PER_ROW);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = DW'(1);
    end else if (image_height > DW'(emap_pkg::HEIGHT_LIMIT)) begin
      h_eff = DW'(emap_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = image_height;
    end
  end

  assign pix.ready = !q_full;
  assign in_fire   = pix.valid && pix.ready;

  emap_front #(
    .MAX_CELLS_PER_ROW (MAX_CELLS_PER_ROW),
    .MAX_STEP          (MAX_STEP)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .s_eff       (s_eff),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .in_fire     (in_fire),
    .edge_value  (pix.edge_value),
    .frame_start (pix.frame_start),
    .push        (push),
    .push_x      (push_x),
    .push_info   (push_info)
  );

  emap_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_info, push_x}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  assign q_x    = q_head[XW-1:0];
  assign q_info = q_head[QW-1:XW];

  emap_back #(
    .MAX_CELLS_PER_ROW (MAX_CELLS_PER_ROW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_x     (q_x),
    .q_info  (q_info),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

// ===== design/emap_front.sv =====
// front end: raster position tracking, block segment OR and classification
module emap_front #(
  parameter int MAX_CELLS_PER_ROW = emap_pkg::MAX_CELLS_PER_ROW,
  parameter int MAX_STEP          = emap_pkg::MAX_STEP
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  restart,
  input  logic [$clog2(MAX_STEP+1)-1:0]         s_eff,
  input  logic [emap_pkg::DIM_W-1:0]            w_eff,
  input  logic [emap_pkg::DIM_W-1:0]            h_eff,
  input  logic                                  in_fire,
  input  logic [emap_pkg::EDGE_W-1:0]           edge_value,
  input  logic                                  frame_start,
  output logic                                  push,
  output logic [$clog2(MAX_CELLS_PER_ROW)-1:0]  push_x,
  output emap_pkg::seg_info_t                   push_info
);

  localparam int XW  = $clog2(MAX_CELLS_PER_ROW);
  localparam int SEW = $clog2(MAX_STEP + 1);
  localparam int SW  = $clog2(MAX_STEP);
  localparam int DW  = emap_pkg::DIM_W;
  localparam int AW  = DW + 2;
  localparam int CW  = emap_pkg::COORD_W;

  logic [DW-1:0] pixel_col, pixel_col_next;
  logic [DW-1:0] pixel_row, pixel_row_next;
  logic [SW-1:0] step_col, step_col_next;
  logic [SW-1:0] step_row, step_row_next;
  logic [XW-1:0] cell_col, cell_col_next;
  logic [CW-1:0] cell_row, cell_row_next;
  logic [DW-1:0] col_base, col_base_next;
  logic [DW-1:0] row_base, row_base_next;
  logic          seg_or, seg_or_next;

  logic [DW-1:0]    pc, pr, cb, rb;
  logic [SW-1:0]    sc, sr;
  logic [XW-1:0]    cc;
  logic [CW-1:0]    cr;
  logic [AW-1:0]    s_ext, w_ext, h_ext, cb_ext, rb_ext;
  logic [SEW:0]     sc_inc, sr_inc, s_cmp;
  logic [DW:0]      pc_inc, pr_inc;
  logic             in_col, in_row, last_col, last_row, seg_end, any;

  // frame start takes this pixel as position zero
  always_comb begin
    pc = frame_start ? '0 : pixel_col;
    pr = frame_start ? '0 : pixel_row;
    sc = frame_start ? '0 : step_col;
    sr = frame_start ? '0 : step_row;
    cc = frame_start ? '0 : cell_col;
    cr = frame_start ? '0 : cell_row;
    cb = frame_start ? '0 : col_base;
    rb = frame_start ? '0 : row_base;
  end

  always_comb begin
    s_ext    = AW'(s_eff);
    w_ext    = AW'(w_eff);
    h_ext    = AW'(h_eff);
    cb_ext   = AW'(cb);
    rb_ext   = AW'(rb);
    s_cmp    = (SEW+1)'(s_eff);
    sc_inc   = (SEW+1)'(sc) + (SEW+1)'(1);
    sr_inc   = (SEW+1)'(sr) + (SEW+1)'(1);
    pc_inc   = (DW+1)'(pc) + (DW+1)'(1);
    pr_inc   = (DW+1)'(pr) + (DW+1)'(1);
    in_col   = (cb_ext + s_ext) <= w_ext;
    in_row   = (rb_ext + s_ext) <= h_ext;
    last_col = (cb_ext + (s_ext << 1)) > w_ext;
    last_row = (rb_ext + (s_ext << 1)) > h_ext;
    seg_end  = sc_inc == s_cmp;
    any      = ((sc != '0) & seg_or) | (edge_value != '0);
  end

  always_comb begin
    push                = in_fire && in_col && in_row && seg_end;
    push_x              = cc;
    push_info.y         = cr;
    push_info.any       = any;
    push_info.row_first = sr == '0;
    push_info.row_last  = sr_inc == s_cmp;
    push_info.last_row  = last_row;
    push_info.last_col  = last_col;
  end

  always_comb begin
    pixel_col_next = pixel_col;
    pixel_row_next = pixel_row;
    step_col_next  = step_col;
    step_row_next  = step_row;
    cell_col_next  = cell_col;
    cell_row_next  = cell_row;
    col_base_next  = col_base;
    row_base_next  = row_base;
    seg_or_next    = seg_or;
    if (restart) begin
      pixel_col_next = '0;
      pixel_row_next = '0;
      step_col_next  = '0;
      step_row_next  = '0;
      cell_col_next  = '0;
      cell_row_next  = '0;
      col_base_next  = '0;
      row_base_next  = '0;
      seg_or_next    = 1'b0;
    end else if (in_fire) begin
      pixel_col_next = DW'(pc_inc);
      pixel_row_next = pr;
      step_col_next  = SW'(sc_inc);
      step_row_next  = sr;
      cell_col_next  = cc;
      cell_row_next  = cr;
      col_base_next  = cb;
      row_base_next  = rb;
      seg_or_next    = any;
      if (sc_inc >= s_cmp) begin
        step_col_next = '0;
        cell_col_next = cc + 1'b1;
        col_base_next = DW'(cb_ext + s_ext);
      end
      if (pc_inc >= (DW+1)'(w_eff)) begin
        pixel_col_next = '0;
        step_col_next  = '0;
        cell_col_next  = '0;
        col_base_next  = '0;
        pixel_row_next = DW'(pr_inc);
        step_row_next  = SW'(sr_inc);
        if (sr_inc >= s_cmp) begin
          step_row_next = '0;
          cell_row_next = cr + 1'b1;
          row_base_next = DW'(rb_ext + s_ext);
        end
        if (pr_inc >= (DW+1)'(h_eff)) begin
          pixel_row_next = '0;
          step_row_next  = '0;
          cell_row_next  = '0;
          row_base_next  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_col <= '0;
      pixel_row <= '0;
      step_col  <= '0;
      step_row  <= '0;
      cell_col  <= '0;
      cell_row  <= '0;
      col_base  <= '0;
      row_base  <= '0;
      seg_or    <= 1'b0;
    end else begin
      pixel_col <= pixel_col_next;
      pixel_row <= pixel_row_next;
      step_col  <= step_col_next;
      step_row  <= step_row_next;
      cell_col  <= cell_col_next;
      cell_row  <= cell_row_next;
      col_base  <= col_base_next;
      row_base  <= row_base_next;
      seg_or    <= seg_or_next;
    end
  end

endmodule

// ===== design/emap_queue.sv =====
// short fifo of segment beats between front and back
module emap_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int DEPTH = emap_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [W-1:0]    slots [DEPTH];
  logic [PW-1:0]   wp, rp;
  logic [CNTW-1:0] count;

  assign full     = count == CNTW'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(push);
      rp    <= rp + PW'(pop);
      count <= count + CNTW'(push) - CNTW'(pop);
    end
  end

endmodule

// ===== design/emap_back.sv =====
// back end: row store update, boundary test and result buffer
module emap_back #(
  parameter int MAX_CELLS_PER_ROW = emap_pkg::MAX_CELLS_PER_ROW
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_empty,
  input  logic [$clog2(MAX_CELLS_PER_ROW)-1:0]  q_x,
  input  emap_pkg::seg_info_t                   q_info,
  output logic                                  q_pop,
  emap_res_if.source                            res
);

  localparam int XW  = $clog2(MAX_CELLS_PER_ROW);
  localparam int CW  = emap_pkg::COORD_W;
  localparam int OD  = emap_pkg::OUT_DEPTH;
  localparam int OPW = $clog2(OD);
  localparam int OCW = $clog2(OD + 1);

  emap_pkg::row_word_t row_mem [MAX_CELLS_PER_ROW];
  emap_pkg::row_word_t rd1, rd2, fwd_word, cur, wd;
  logic                fwd1, fwd2;
  logic [XW-1:0]       ra1, ra2;

  logic                b_valid;
  logic [XW-1:0]       b_x;
  emap_pkg::seg_info_t b_info;

  logic          left_prior, right_prior, acc_final, inner, all4;
  logic          emit1, emit2;
  emap_pkg::res_t r1, r2, first;
  logic [OCW-1:0] n_push;
  logic [OCW:0]   need;
  logic           out_pop;

  emap_pkg::res_t obuf [OD];
  logic [OPW-1:0] wp, rp;
  logic [OCW-1:0] count;

  // room for every result of the beats in flight
  always_comb begin
    need  = (OCW+1)'(count) + (b_valid ? (OCW+1)'(4) : (OCW+1)'(2));
    q_pop = !q_empty && (need <= (OCW+1)'(OD));
    ra1   = q_x;
    ra2   = q_x + 1'b1;
  end

  always_comb begin
    cur         = fwd1 ? fwd_word : rd1;
    right_prior = fwd2 ? fwd_word.prior : rd2.prior;
    acc_final   = (!b_info.row_first & cur.acc) | b_info.any;
    if (b_info.row_last) begin
      wd.older = cur.prior;
      wd.prior = acc_final;
      wd.acc   = 1'b0;
    end else begin
      wd.older = cur.older;
      wd.prior = cur.prior;
      wd.acc   = acc_final;
    end
    inner = (b_info.y > CW'(1)) && (b_x != '0) && !b_info.last_col && cur.prior;
    all4  = cur.older && acc_final && left_prior && right_prior;
    emit1 = b_valid && b_info.row_last && (b_info.y != '0);
    emit2 = b_valid && b_info.row_last && b_info.last_row;

    r1.out_row      = b_info.y - 1'b1;
    r1.out_col      = CW'(b_x);
    r1.boundary_bit = inner && !all4;
    r1.frame_end    = 1'b0;
    r2.out_row      = b_info.y;
    r2.out_col      = CW'(b_x);
    r2.boundary_bit = 1'b0;
    r2.frame_end    = b_info.last_col;

    first  = emit1 ? r1 : r2;
    n_push = OCW'(emit1) + OCW'(emit2);
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      row_mem[b_x] <= wd;
    end
    rd1      <= row_mem[ra1];
    rd2      <= row_mem[ra2];
    fwd_word <= wd;
    b_x      <= q_x;
    b_info   <= q_info;
    if (b_valid && b_info.row_last) begin
      left_prior <= cur.prior;
    end
    if (emit1 || emit2) begin
      obuf[wp] <= first;
    end
    if (emit1 && emit2) begin
      obuf[wp + 1'b1] <= r2;
    end
  end

  assign out_pop = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd1    <= 1'b0;
      fwd2    <= 1'b0;
      wp      <= '0;
      rp      <= '0;
      count   <= '0;
    end else begin
      b_valid <= q_pop;
      fwd1    <= b_valid && (b_x == ra1);
      fwd2    <= b_valid && (b_x == ra2);
      wp      <= wp + OPW'(n_push);
      rp      <= rp + OPW'(out_pop);
      count   <= count + n_push - OCW'(out_pop);
    end
  end

  always_comb begin
    res.valid        = count != '0;
    res.out_row      = obuf[rp].out_row;
    res.out_col      = obuf[rp].out_col;
    res.boundary_bit = obuf[rp].boundary_bit;
    res.frame_end    = obuf[rp].frame_end;
  end

endmodule
